// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// next-cycle implication
`define ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// ----- sv/dpdb_pkg.sv -----
`timescale 1ns / 1ps

package dpdb_pkg;

    localparam int PANEL_WIDTH_DEF  = 400;
    localparam int PANEL_HEIGHT_DEF = 300;

    localparam int BOX_W = 11;

    localparam logic [2:0] ACT_WRITE = 3'd0;
    localparam logic [2:0] ACT_CLEAR = 3'd1;
    localparam logic [2:0] ACT_READ  = 3'd2;
    localparam logic [2:0] ACT_TAKE  = 3'd3;
    localparam logic [2:0] ACT_FORCE = 3'd4;

    localparam logic [7:0] LUM_R = 8'd77;
    localparam logic [7:0] LUM_G = 8'd150;
    localparam logic [7:0] LUM_B = 8'd29;

    localparam logic [7:0] SCALE5 [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

    // indexed by {y[1:0], x[1:0]}
    localparam logic [3:0] BAYER [16] = '{
        4'd0,  4'd8,  4'd2,  4'd10,
        4'd12, 4'd4,  4'd14, 4'd6,
        4'd3,  4'd11, 4'd1,  4'd9,
        4'd15, 4'd7,  4'd13, 4'd5
    };

    // v*255/63 == 4v + floor(v/21)
    function automatic logic [7:0] scale6(input logic [5:0] v);
        logic [1:0] adj;
        adj = (v >= 6'd42) ? 2'd2 : ((v >= 6'd21) ? 2'd1 : 2'd0);
        return {v, 2'b00} + 8'(adj) + 8'(v == 6'd63);
    endfunction

    typedef struct packed {
        logic load;
        logic calc;
        logic mem_rd;
        logic sweep;
        logic sweep_white;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] act;
        logic       sweep_last;
    } dp_status_t;

endpackage

// ----- sv/dpdb_ctrl.sv -----
`timescale 1ns / 1ps

module dpdb_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  dpdb_pkg::dp_status_t  status,
    output dpdb_pkg::dp_cmd_t     cmd,
    output logic                  busy
);
    import dpdb_pkg::*;

    typedef enum logic [5:0] {
        ST_INIT  = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_CALC  = 6'b000100,
        ST_READ  = 6'b001000,
        ST_CLEAR = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.sweep       = 1'b1;
                cmd.sweep_white = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = (status.act == ACT_CLEAR) ? ST_CLEAR : ST_READ;
            end
            ST_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_FIN;
            end
            ST_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ----- sv/dpdb_datapath.sv -----
`timescale 1ns / 1ps

module dpdb_datapath #(
    parameter int PANEL_WIDTH  = dpdb_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = dpdb_pkg::PANEL_HEIGHT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dpdb_pkg::dp_cmd_t     cmd,
    output dpdb_pkg::dp_status_t  status,
    input  logic [2:0]            action,
    input  logic [9:0]            x,
    input  logic [9:0]            y,
    input  logic [15:0]           color,
    input  logic                  fill_white,
    input  logic [13:0]           byte_index,
    output logic                  done,
    output logic [7:0]            read_byte,
    output logic                  changed,
    output logic [8:0]            dirty_left,
    output logic [8:0]            dirty_top,
    output logic signed [9:0]     dirty_right,
    output logic signed [9:0]     dirty_bottom,
    output logic                  full_refresh,
    output logic                  refresh_needed
);
    import dpdb_pkg::*;

    localparam int STORE_BYTES = ((PANEL_WIDTH + 1) >> 1) * ((PANEL_HEIGHT + 3) >> 2);
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int OFF_W       = ADDR_W + 1;
    localparam int ROWS        = PANEL_HEIGHT >> 2;

    localparam logic signed [BOX_W-1:0] BOX_W_FULL = BOX_W'(PANEL_WIDTH);
    localparam logic signed [BOX_W-1:0] BOX_H_FULL = BOX_W'(PANEL_HEIGHT);
    localparam logic signed [BOX_W-1:0] BOX_W_LAST = BOX_W'(PANEL_WIDTH - 1);
    localparam logic signed [BOX_W-1:0] BOX_H_LAST = BOX_W'(PANEL_HEIGHT - 1);
    localparam logic signed [BOX_W-1:0] BOX_NONE   = '1;

    logic [2:0]  act_reg;
    logic [9:0]  x_reg;
    logic [9:0]  y_reg;
    logic [15:0] color_reg;
    logic        fill_reg;
    logic [13:0] idx_reg;

    logic [ADDR_W-1:0] addr_reg;
    logic              ok_reg;
    logic              want_reg;
    logic [7:0]        mask_reg;
    logic [7:0]        q_reg;
    logic [ADDR_W-1:0] sweep_reg;

    logic [7:0] store_mem [STORE_BYTES];

    logic signed [BOX_W-1:0] left_reg, top_reg, right_reg, bottom_reg;
    logic signed [BOX_W-1:0] left_next, top_next, right_next, bottom_next;
    logic                    force_reg, force_next;

    logic done_reg;
    logic [7:0] read_byte_reg;
    logic changed_reg;
    logic [8:0] left_out_reg, top_out_reg;
    logic signed [9:0] right_out_reg, bottom_out_reg;
    logic full_out_reg, needed_out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg   <= action;
            x_reg     <= x;
            y_reg     <= y;
            color_reg <= color;
            fill_reg  <= fill_white;
            idx_reg   <= byte_index;
        end
    end

    // address, bit mask and dither decision
    logic              in_panel;
    logic [9:0]        iy;
    logic [OFF_W-1:0]  off;
    logic              off_ok;
    logic              idx_ok;
    logic [7:0]        r8, g8, b8;
    logic [17:0]       lum_sum;
    logic [7:0]        thr;
    logic              want;

    always_comb
    begin
        in_panel = (x_reg < 10'(PANEL_WIDTH)) && (y_reg < 10'(PANEL_HEIGHT));
        iy       = 10'(PANEL_HEIGHT - 1) - y_reg;
        off      = OFF_W'(x_reg[9:1]) * OFF_W'(ROWS) + OFF_W'(iy[9:2]);
        off_ok   = (32'(off) < 32'(STORE_BYTES));
        idx_ok   = (32'(idx_reg) < 32'(STORE_BYTES));
        r8       = SCALE5[color_reg[15:11]];
        g8       = scale6(color_reg[10:5]);
        b8       = SCALE5[color_reg[4:0]];
        lum_sum  = 18'(LUM_R) * 18'(r8) + 18'(LUM_G) * 18'(g8) + 18'(LUM_B) * 18'(b8);
        thr      = {BAYER[{y_reg[1:0], x_reg[1:0]}], 4'b1000};
        want     = (lum_sum[15:8] >= thr);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            if (act_reg == ACT_READ)
            begin
                addr_reg <= ADDR_W'(idx_reg);
                ok_reg   <= idx_ok;
            end
            else
            begin
                addr_reg <= ADDR_W'(off);
                ok_reg   <= in_panel && off_ok;
            end
            want_reg <= want;
            mask_reg <= 8'h80 >> {iy[1:0], x_reg[0]};
        end
    end

    // store update
    logic              have;
    logic              flip;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              sweep_last;

    always_comb
    begin
        have       = |(q_reg & mask_reg);
        flip       = (act_reg == ACT_WRITE) && ok_reg && (want_reg != have);
        mem_we     = cmd.sweep || (cmd.finish && flip);
        mem_waddr  = cmd.sweep ? sweep_reg : addr_reg;
        if (cmd.sweep)
        begin
            mem_wdata = (cmd.sweep_white || fill_reg) ? 8'hFF : 8'h00;
        end
        else
        begin
            mem_wdata = want_reg ? (q_reg | mask_reg) : (q_reg & ~mask_reg);
        end
        sweep_last = (sweep_reg == ADDR_W'(STORE_BYTES - 1));
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.mem_rd)
        begin
            q_reg <= store_mem[addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= '0;
        end
        else if (cmd.sweep)
        begin
            sweep_reg <= sweep_last ? '0 : sweep_reg + 1'b1;
        end
    end

    assign status.act        = act_reg;
    assign status.sweep_last = sweep_last;

    // dirty box
    logic signed [BOX_W-1:0] xs, ys;
    logic signed [BOX_W-1:0] rep_left, rep_top, rep_right, rep_bottom;
    logic                    rep_force;

    always_comb
    begin
        xs          = signed'(BOX_W'(x_reg));
        ys          = signed'(BOX_W'(y_reg));
        left_next   = left_reg;
        top_next    = top_reg;
        right_next  = right_reg;
        bottom_next = bottom_reg;
        force_next  = force_reg;
        if (cmd.finish)
        begin
            priority if (act_reg == ACT_WRITE)
            begin
                if (flip)
                begin
                    if (xs < left_reg)   left_next   = xs;
                    if (xs > right_reg)  right_next  = xs;
                    if (ys < top_reg)    top_next    = ys;
                    if (ys > bottom_reg) bottom_next = ys;
                end
            end
            else if (act_reg == ACT_CLEAR || act_reg == ACT_FORCE)
            begin
                left_next   = '0;
                top_next    = '0;
                right_next  = BOX_W_LAST;
                bottom_next = BOX_H_LAST;
                force_next  = 1'b1;
            end
            else if (act_reg == ACT_TAKE)
            begin
                left_next   = BOX_W_FULL;
                top_next    = BOX_H_FULL;
                right_next  = BOX_NONE;
                bottom_next = BOX_NONE;
                force_next  = 1'b0;
            end
            else
            begin
                force_next = force_reg;
            end
        end
        if (act_reg == ACT_TAKE)
        begin
            rep_left   = left_reg;
            rep_top    = top_reg;
            rep_right  = right_reg;
            rep_bottom = bottom_reg;
            rep_force  = force_reg;
        end
        else
        begin
            rep_left   = left_next;
            rep_top    = top_next;
            rep_right  = right_next;
            rep_bottom = bottom_next;
            rep_force  = force_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            top_reg    <= '0;
            right_reg  <= BOX_W_LAST;
            bottom_reg <= BOX_H_LAST;
            force_reg  <= 1'b1;
        end
        else
        begin
            left_reg   <= left_next;
            top_reg    <= top_next;
            right_reg  <= right_next;
            bottom_reg <= bottom_next;
            force_reg  <= force_next;
        end
    end

    // result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            read_byte_reg  <= (act_reg == ACT_READ && ok_reg) ? q_reg : 8'h00;
            changed_reg    <= flip;
            left_out_reg   <= rep_left[8:0];
            top_out_reg    <= rep_top[8:0];
            right_out_reg  <= rep_right[9:0];
            bottom_out_reg <= rep_bottom[9:0];
            full_out_reg   <= rep_force;
            needed_out_reg <= ((rep_right >= rep_left) && (rep_bottom >= rep_top))
                              || rep_force;
        end
    end

    assign done           = done_reg;
    assign read_byte      = read_byte_reg;
    assign changed        = changed_reg;
    assign dirty_left     = left_out_reg;
    assign dirty_top      = top_out_reg;
    assign dirty_right    = right_out_reg;
    assign dirty_bottom   = bottom_out_reg;
    assign full_refresh   = full_out_reg;
    assign refresh_needed = needed_out_reg;

endmodule

// ----- sv/dithered_pixel_packer_dirty_box_core.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

// A request is taken when start is high and busy is low. Pixel writes, byte reads,
// take-box, force-refresh and unused-code requests each pass load, dither and address,
// frame store read, then update and result; done pulses for one cycle with the result
// and start may be given in that same cycle. The frame store is a single memory with
// one read and one write port, so a pixel write is a read followed by a write. A clear
// request walks the store one byte per cycle. After reset busy stays high while the
// store is filled with white. Results cannot be stalled: sample them on done.
module dithered_pixel_packer_dirty_box_core #(
    parameter int PANEL_WIDTH  = dpdb_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = dpdb_pkg::PANEL_HEIGHT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        action,
    input  logic [9:0]        x,
    input  logic [9:0]        y,
    input  logic [15:0]       color,
    input  logic              fill_white,
    input  logic [13:0]       byte_index,
    output logic              done,
    output logic [7:0]        read_byte,
    output logic              changed,
    output logic [8:0]        dirty_left,
    output logic [8:0]        dirty_top,
    output logic signed [9:0] dirty_right,
    output logic signed [9:0] dirty_bottom,
    output logic              full_refresh,
    output logic              refresh_needed
);
    import dpdb_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    dpdb_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    dpdb_datapath #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .action         (action),
        .x              (x),
        .y              (y),
        .color          (color),
        .fill_white     (fill_white),
        .byte_index     (byte_index),
        .done           (done),
        .read_byte      (read_byte),
        .changed        (changed),
        .dirty_left     (dirty_left),
        .dirty_top      (dirty_top),
        .dirty_right    (dirty_right),
        .dirty_bottom   (dirty_bottom),
        .full_refresh   (full_refresh),
        .refresh_needed (refresh_needed)
    );

    `ASSERT_IMP(a_done_when_idle, clk, rst_n, done, !busy)
    `ASSERT_NXT(a_accept_goes_busy, clk, rst_n, start && !busy, busy)
    `ASSERT_IMP(a_change_marks_dirty, clk, rst_n, done && changed, refresh_needed)
    `ASSERT_IMP(a_change_no_read_data, clk, rst_n, done && changed, read_byte == 8'd0)

endmodule

// ----- sim/dithered_pixel_packer_dirty_box_core_tb.sv -----
`timescale 1ns / 1ps

module dithered_pixel_packer_dirty_box_core_tb;

    import dpdb_pkg::*;

    localparam int PANEL_W     = PANEL_WIDTH_DEF;
    localparam int PANEL_H     = PANEL_HEIGHT_DEF;
    localparam int STORE_BYTES = ((PANEL_W + 1) >> 1) * ((PANEL_H + 3) >> 2);
    localparam int N_RAND      = 725;
    localparam int MAX_CLEARS  = 5;
    localparam int IDLE_PCT    = 35;
    localparam int TAIL_CYCLES = 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_PRINTS  = 100;

    localparam logic [2:0] ACT_SPARE [3] = '{3'd5, 3'd6, 3'd7};

    localparam int DITHER_MAT [4][4] = '{
        '{ 0,  8,  2, 10},
        '{12,  4, 14,  6},
        '{ 3, 11,  1,  9},
        '{15,  7, 13,  5}
    };

    typedef struct packed {
        logic [2:0]  act;
        logic [9:0]  px;
        logic [9:0]  py;
        logic [15:0] rgb;
        logic        fill;
        logic [13:0] idx;
    } pix_req_t;

    typedef struct packed {
        logic [7:0] rd;
        logic       chg;
        logic [8:0] left;
        logic [8:0] top;
        logic [9:0] right;
        logic [9:0] bottom;
        logic       full;
        logic       need;
    } frame_res_t;

    typedef struct packed {
        pix_req_t   req;
        logic       typed;
        frame_res_t want;
    } dir_row_t;

    localparam frame_res_t NO_RES = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [2:0]  action = ACT_READ;
    logic [9:0]  x = '0;
    logic [9:0]  y = '0;
    logic [15:0] color = '0;
    logic        fill_white = 1'b0;
    logic [13:0] byte_index = '0;
    logic        busy;
    logic        done;
    logic [7:0]  read_byte;
    logic        changed;
    logic [8:0]  dirty_left;
    logic [8:0]  dirty_top;
    logic signed [9:0] dirty_right;
    logic signed [9:0] dirty_bottom;
    logic        full_refresh;
    logic        refresh_needed;

    logic [7:0]  shadow_fb [STORE_BYTES];
    int          box_l;
    int          box_t;
    int          box_r;
    int          box_b;
    bit          force_flag;

    frame_res_t  pending_res [$];
    frame_res_t  res_want;
    dir_row_t    dir_rows [$];
    int          err_count = 0;
    int unsigned cycle_cnt = 0;
    bit          quiet = 1'b0;

    dithered_pixel_packer_dirty_box_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .x              (x),
        .y              (y),
        .color          (color),
        .fill_white     (fill_white),
        .byte_index     (byte_index),
        .done           (done),
        .read_byte      (read_byte),
        .changed        (changed),
        .dirty_left     (dirty_left),
        .dirty_top      (dirty_top),
        .dirty_right    (dirty_right),
        .dirty_bottom   (dirty_bottom),
        .full_refresh   (full_refresh),
        .refresh_needed (refresh_needed)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < MAX_PRINTS)
            $display("tb: mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        err_count++;
    endtask

    function automatic frame_res_t box_res(input int rd, input int chg, input int l,
                                           input int t, input int r, input int b,
                                           input int f, input int n);
        frame_res_t res;
        res.rd     = 8'(rd);
        res.chg    = 1'(chg);
        res.left   = 9'(l);
        res.top    = 9'(t);
        res.right  = 10'(r);
        res.bottom = 10'(b);
        res.full   = 1'(f);
        res.need   = 1'(n);
        return res;
    endfunction

    function automatic frame_res_t box_now();
        bit dirty;
        dirty = (box_r >= box_l) && (box_b >= box_t);
        return box_res(0, 0, box_l, box_t, box_r, box_b, force_flag, dirty || force_flag);
    endfunction

    function automatic void request_full_pred();
        force_flag = 1'b1;
        box_l = 0;
        box_t = 0;
        box_r = PANEL_W - 1;
        box_b = PANEL_H - 1;
    endfunction

    function automatic int pix_off(input int px, input int py);
        int iy;
        iy = PANEL_H - 1 - py;
        return (px >> 1) * (PANEL_H >> 2) + (iy >> 2);
    endfunction

    function automatic frame_res_t dither_step(input pix_req_t r);
        frame_res_t res;
        int px;
        int py;
        int iy;
        int off;
        int bitn;
        int cr;
        int cg;
        int cb;
        int lum;
        bit want_w;
        logic [7:0] rd;
        logic chg;
        rd  = '0;
        chg = 1'b0;
        px  = int'(r.px);
        py  = int'(r.py);
        case (r.act)
            ACT_WRITE:
            begin
                if (px < PANEL_W && py < PANEL_H)
                begin
                    iy   = PANEL_H - 1 - py;
                    off  = pix_off(px, py);
                    bitn = 7 - (((iy & 3) << 1) | (px & 1));
                    cr   = int'(r.rgb[15:11]) * 255 / 31;
                    cg   = int'(r.rgb[10:5]) * 255 / 63;
                    cb   = int'(r.rgb[4:0]) * 255 / 31;
                    lum  = (77 * cr + 150 * cg + 29 * cb) >> 8;
                    want_w = lum >= DITHER_MAT[py & 3][px & 3] * 16 + 8;
                    if (off < STORE_BYTES && shadow_fb[off][bitn] != want_w)
                    begin
                        shadow_fb[off][bitn] = want_w;
                        if (px < box_l) box_l = px;
                        if (px > box_r) box_r = px;
                        if (py < box_t) box_t = py;
                        if (py > box_b) box_b = py;
                        chg = 1'b1;
                    end
                end
            end
            ACT_CLEAR:
            begin
                foreach (shadow_fb[i])
                    shadow_fb[i] = r.fill ? 8'hFF : 8'h00;
                request_full_pred();
            end
            ACT_READ:
            begin
                if (int'(r.idx) < STORE_BYTES)
                    rd = shadow_fb[r.idx];
            end
            ACT_TAKE:
            begin
                res = box_now();
                box_l = PANEL_W;
                box_t = PANEL_H;
                box_r = -1;
                box_b = -1;
                force_flag = 1'b0;
                return res;
            end
            ACT_FORCE:
            begin
                request_full_pred();
            end
            default:
            begin
            end
        endcase
        res     = box_now();
        res.rd  = rd;
        res.chg = chg;
        return res;
    endfunction

    task automatic add_row(input logic [2:0] act, input int px, input int py, input int rgb,
                           input int fill, input int idx, input bit typed,
                           input frame_res_t want);
        dir_row_t row;
        row.req.act  = act;
        row.req.px   = 10'(px);
        row.req.py   = 10'(py);
        row.req.rgb  = 16'(rgb);
        row.req.fill = 1'(fill);
        row.req.idx  = 14'(idx);
        row.typed    = typed;
        row.want     = want;
        dir_rows.push_back(row);
    endtask

    task automatic issue(input pix_req_t r, input bit typed, input frame_res_t want);
        int gap;
        frame_res_t pred;
        gap = (quiet || $urandom_range(99) >= IDLE_PCT) ? 0 : $urandom_range(8, 1);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        action     <= r.act;
        x          <= r.px;
        y          <= r.py;
        color      <= r.rgb;
        fill_white <= r.fill;
        byte_index <= r.idx;
        do @(posedge clk); while (busy);
        pred = dither_step(r);
        pending_res.push_back(typed ? want : pred);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_res.size() != 0) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_res.size() == 0)
            begin
                report_mismatch("result with no request pending", 1, 0);
            end
            else
            begin
                res_want = pending_res.pop_front();
                if (read_byte !== res_want.rd)
                    report_mismatch("read_byte", read_byte, res_want.rd);
                if (changed !== res_want.chg)
                    report_mismatch("changed", changed, res_want.chg);
                if (dirty_left !== res_want.left)
                    report_mismatch("dirty_left", dirty_left, res_want.left);
                if (dirty_top !== res_want.top)
                    report_mismatch("dirty_top", dirty_top, res_want.top);
                if (dirty_right !== res_want.right)
                    report_mismatch("dirty_right", dirty_right, res_want.right);
                if (dirty_bottom !== res_want.bottom)
                    report_mismatch("dirty_bottom", dirty_bottom, res_want.bottom);
                if (full_refresh !== res_want.full)
                    report_mismatch("full_refresh", full_refresh, res_want.full);
                if (refresh_needed !== res_want.need)
                    report_mismatch("refresh_needed", refresh_needed, res_want.need);
            end
        end
    end

    initial
    begin
        frame_res_t full_box;
        frame_res_t empty_box;
        pix_req_t   r;
        int         roll;
        int         mode;
        int         clears;
        int         hx;
        int         hy;

        foreach (shadow_fb[i])
            shadow_fb[i] = 8'hFF;
        request_full_pred();

        full_box  = box_res(0, 0, 0, 0, PANEL_W - 1, PANEL_H - 1, 1, 1);
        empty_box = box_res(0, 0, PANEL_W, PANEL_H, -1, -1, 0, 0);

        add_row(ACT_TAKE, 0, 0, 0, 0, 0, 1'b1, full_box);
        add_row(ACT_TAKE, 0, 0, 0, 0, 0, 1'b1, empty_box);
        add_row(ACT_READ, 0, 0, 0, 0, 0, 1'b1,
                box_res(8'hFF, 0, PANEL_W, PANEL_H, -1, -1, 0, 0));
        add_row(ACT_READ, 0, 0, 0, 0, STORE_BYTES - 1, 1'b1,
                box_res(8'hFF, 0, PANEL_W, PANEL_H, -1, -1, 0, 0));
        add_row(ACT_READ, 0, 0, 0, 0, STORE_BYTES, 1'b1, empty_box);
        add_row(ACT_READ, 0, 0, 0, 0, 16383, 1'b1, empty_box);
        add_row(ACT_WRITE, 1023, 5, 0, 0, 0, 1'b1, empty_box);
        add_row(ACT_WRITE, 7, 1023, 0, 0, 0, 1'b1, empty_box);
        add_row(ACT_WRITE, PANEL_W, 0, 0, 0, 0, 1'b1, empty_box);
        add_row(ACT_WRITE, 0, PANEL_H, 0, 0, 0, 1'b1, empty_box);
        add_row(ACT_WRITE, 0, 0, 16'hFFFF, 0, 0, 1'b1, empty_box);
        add_row(ACT_WRITE, 0, 0, 16'h0000, 0, 0, 1'b1, box_res(0, 1, 0, 0, 0, 0, 0, 1));
        add_row(ACT_READ, 0, 0, 0, 0, pix_off(0, 0), 1'b1,
                box_res(8'hFD, 0, 0, 0, 0, 0, 0, 1));
        add_row(ACT_WRITE, PANEL_W - 1, PANEL_H - 1, 16'h0000, 0, 0, 1'b0, NO_RES);
        add_row(ACT_WRITE, PANEL_W - 1, PANEL_H - 1, 16'hFFFF, 0, 0, 1'b0, NO_RES);
        add_row(ACT_WRITE, 1, 2, 16'hF800, 0, 0, 1'b0, NO_RES);
        add_row(ACT_WRITE, 2, 3, 16'h07E0, 0, 0, 1'b0, NO_RES);
        add_row(ACT_WRITE, 3, 1, 16'h001F, 0, 0, 1'b0, NO_RES);
        add_row(ACT_FORCE, 0, 0, 0, 0, 0, 1'b1, full_box);
        add_row(ACT_TAKE, 0, 0, 0, 0, 0, 1'b1, full_box);
        add_row(ACT_CLEAR, 0, 0, 0, 0, 0, 1'b1, full_box);
        add_row(ACT_READ, 0, 0, 0, 0, 5, 1'b1, full_box);
        add_row(ACT_WRITE, 5, 7, 16'h0000, 0, 0, 1'b0, NO_RES);
        add_row(ACT_CLEAR, 0, 0, 0, 1, 0, 1'b1, full_box);
        add_row(ACT_SPARE[0], 9, 9, 16'h0000, 0, 0, 1'b0, NO_RES);
        add_row(ACT_SPARE[1], 0, 0, 0, 0, 0, 1'b0, NO_RES);
        add_row(ACT_SPARE[2], 0, 0, 0, 0, 0, 1'b0, NO_RES);
        add_row(ACT_TAKE, 0, 0, 0, 0, 0, 1'b0, NO_RES);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            issue(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

        clears = 0;
        for (int n = 0; n < N_RAND; n++)
        begin
            if (n == 100 || n == 500)
                drain();
            quiet = (n >= 250 && n < 420);

            r.act  = ACT_WRITE;
            r.px   = 10'($urandom);
            r.py   = 10'($urandom);
            r.rgb  = 16'($urandom);
            r.fill = 1'($urandom);
            r.idx  = 14'($urandom);
            hx     = $urandom_range(15);
            hy     = $urandom_range(PANEL_H - 1, PANEL_H - 8);

            roll = $urandom_range(999);
            if (roll < 8 && clears < MAX_CLEARS)
            begin
                r.act = ACT_CLEAR;
                clears++;
            end
            else if (roll < 700)
            begin
                mode = $urandom_range(99);
                if (mode < 40)
                begin
                    r.px = 10'(hx);
                    r.py = 10'(hy);
                end
                else if (mode < 90)
                begin
                    r.px = 10'($urandom_range(PANEL_W - 1));
                    r.py = 10'($urandom_range(PANEL_H - 1));
                end
                if ($urandom_range(99) < 20)
                    r.rgb = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            end
            else if (roll < 850)
            begin
                r.act = ACT_READ;
                mode  = $urandom_range(99);
                if (mode < 45)
                    r.idx = 14'(pix_off(hx, hy));
                else if (mode < 90)
                    r.idx = 14'($urandom_range(STORE_BYTES - 1));
            end
            else if (roll < 930)
                r.act = ACT_TAKE;
            else if (roll < 970)
                r.act = ACT_FORCE;
            else
                r.act = ACT_SPARE[$urandom_range(2)];

            issue(r, 1'b0, NO_RES);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
